FILE: design/htfd_pkg.sv
`default_nettype none
package htfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RAW_W       = 20;
   localparam int unsigned HUM_W       = 14;
   localparam int unsigned TEMP_W      = 15;
   localparam int unsigned POS_W       = 3;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [RAW_W-1:0]  raw_type;
   typedef logic [POS_W-1:0]  pos_type;

   typedef enum logic [1:0] {
      RC_OK       = 2'd0,
      RC_BUSY     = 2'd1,
      RC_CRC_BAD  = 2'd2,
      RC_STATUS   = 2'd3
   } result_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATUS_MASK   = 1'b0,
      CSR_STATUS_EXPECT = 1'b1
   } csr_index_type;

   localparam byte_type CRC_POLY           = 8'h31;
   localparam byte_type CRC_INIT           = 8'hFF;
   localparam int unsigned BUSY_BIT        = 7;
   localparam byte_type STATUS_MASK_RESET  = 8'h98;
   localparam byte_type STATUS_EXPECT_RESET = 8'h18;

   // byte positions, counted as bytes taken so far
   localparam pos_type POS_IDLE   = 3'd0;
   localparam pos_type POS_HUM_HI = 3'd1;
   localparam pos_type POS_HUM_MD = 3'd2;
   localparam pos_type POS_SPLIT  = 3'd3;
   localparam pos_type POS_TMP_MD = 3'd4;
   localparam pos_type POS_TMP_LO = 3'd5;
   localparam pos_type POS_CRC    = 3'd6;

   localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
   localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

   function automatic byte_type crc8_update(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: design/htfd_req_if.sv
`default_nettype none
interface htfd_req_if;
   logic                   valid;
   logic                   ready;
   htfd_pkg::byte_type     data_byte;
   logic                   frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface
`default_nettype wire

FILE: design/htfd_rsp_if.sv
`default_nettype none
interface htfd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [htfd_pkg::HUM_W-1:0]            humidity_centi;
   logic signed [htfd_pkg::TEMP_W-1:0]    temperature_centi;
   htfd_pkg::result_code_type             result_code;
   htfd_pkg::byte_type                    status_copy;

   modport source (output valid, output humidity_centi, output temperature_centi,
                   output result_code, output status_copy, input ready);
   modport sink   (input valid, input humidity_centi, input temperature_centi,
                   input result_code, input status_copy, output ready);
endinterface
`default_nettype wire

FILE: design/htfd_csr_if.sv
`default_nettype none
interface htfd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [htfd_pkg::CSR_INDEX_W-1:0]    index;
   htfd_pkg::byte_type                  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/humidity_temp_frame_decoder.sv
// Decodes a seven-byte humidity/temperature sensor reply (status, five data bytes, CRC-8
// poly 0x31 init 0xFF) taken one byte per request, and returns one result per complete
// frame: humidity in centi-percent, signed temperature in centi-degrees, a result code
// (busy, CRC mismatch, status mismatch under status_mask/status_expect) and the status
// byte. A byte is taken every cycle: the frame state and the result register update in
// the cycle of the request, and the block only stalls while an untaken result sits in
// the result register, so throughput is one byte per clock and a result appears in the
// cycle after the CRC byte is taken. Bytes without frame_start while idle are dropped;
// frame_start in mid-frame restarts the frame. Register writes are always accepted.
`default_nettype none
module humidity_temp_frame_decoder (
   input  wire         clock,
   input  wire         reset,
   htfd_req_if.sink    req_chan,
   htfd_rsp_if.source  rsp_chan,
   htfd_csr_if.sink    csr_chan
);

   htfd_pkg::byte_type   status_mask_ff, status_expect_ff;
   htfd_pkg::pos_type    pos_ff, pos_in;
   htfd_pkg::byte_type   crc_ff, crc_in;
   htfd_pkg::byte_type   status_ff, status_in;
   htfd_pkg::raw_type    hum_raw_ff, hum_raw_in;
   htfd_pkg::raw_type    tmp_raw_ff, tmp_raw_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [htfd_pkg::HUM_W-1:0]           out_hum_ff, out_hum_in;
   logic [htfd_pkg::TEMP_W-1:0]          out_tmp_ff, out_tmp_in;
   htfd_pkg::result_code_type            out_code_ff, out_code_in;
   htfd_pkg::byte_type                   out_status_ff, out_status_in;

   logic                                 accept;
   htfd_pkg::byte_type                   b;
   logic [htfd_pkg::RAW_W+htfd_pkg::HUM_W-1:0]  hum_prod;
   logic [htfd_pkg::RAW_W+htfd_pkg::TEMP_W-1:0] tmp_prod;
   logic [htfd_pkg::HUM_W-1:0]           hum_centi;
   logic [htfd_pkg::TEMP_W-1:0]          tmp_centi;
   htfd_pkg::result_code_type            code;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign csr_chan.ready = 1'b1;

   // scaling from the captured raw readings
   assign hum_prod  = {{htfd_pkg::HUM_W{1'b0}}, hum_raw_ff}
                      * {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::HUM_SCALE};
   assign tmp_prod  = {{htfd_pkg::TEMP_W{1'b0}}, tmp_raw_ff}
                      * {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::TEMP_SCALE};
   assign hum_centi = hum_prod[htfd_pkg::RAW_W+htfd_pkg::HUM_W-1:htfd_pkg::RAW_W];
   assign tmp_centi = tmp_prod[htfd_pkg::RAW_W+htfd_pkg::TEMP_W-1:htfd_pkg::RAW_W]
                      - htfd_pkg::TEMP_OFFSET;

   always_comb begin
      if (status_ff[htfd_pkg::BUSY_BIT]) begin
         code = htfd_pkg::RC_BUSY;
      end else if (crc_ff != b) begin
         code = htfd_pkg::RC_CRC_BAD;
      end else if ((status_ff & status_mask_ff) != status_expect_ff) begin
         code = htfd_pkg::RC_STATUS;
      end else begin
         code = htfd_pkg::RC_OK;
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      status_in     = status_ff;
      hum_raw_in    = hum_raw_ff;
      tmp_raw_in    = tmp_raw_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_hum_in    = out_hum_ff;
      out_tmp_in    = out_tmp_ff;
      out_code_in   = out_code_ff;
      out_status_in = out_status_ff;
      if (accept) begin
         if (req_chan.frame_start) begin
            status_in = b;
            crc_in    = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, b);
            pos_in    = htfd_pkg::POS_HUM_HI;
         end else if (pos_ff == htfd_pkg::POS_IDLE || pos_ff > htfd_pkg::POS_CRC) begin
            pos_in = htfd_pkg::POS_IDLE;
         end else if (pos_ff < htfd_pkg::POS_CRC) begin
            case (pos_ff)
               htfd_pkg::POS_HUM_HI: hum_raw_in[19:12] = b;
               htfd_pkg::POS_HUM_MD: hum_raw_in[11:4]  = b;
               htfd_pkg::POS_SPLIT: begin
                  hum_raw_in[3:0]   = b[7:4];
                  tmp_raw_in[19:16] = b[3:0];
               end
               htfd_pkg::POS_TMP_MD: tmp_raw_in[15:8] = b;
               default:              tmp_raw_in[7:0]  = b;
            endcase
            crc_in = htfd_pkg::crc8_update(crc_ff, b);
            pos_in = pos_ff + htfd_pkg::POS_W'(1);
         end else begin
            out_valid_in  = 1'b1;
            out_code_in   = code;
            out_status_in = status_ff;
            out_hum_in    = (code == htfd_pkg::RC_OK) ? hum_centi : '0;
            out_tmp_in    = (code == htfd_pkg::RC_OK) ? tmp_centi : '0;
            pos_in        = htfd_pkg::POS_IDLE;
            crc_in        = htfd_pkg::CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= htfd_pkg::POS_IDLE;
         crc_ff           <= htfd_pkg::CRC_INIT;
         status_ff        <= '0;
         hum_raw_ff       <= '0;
         tmp_raw_ff       <= '0;
         out_valid_ff     <= 1'b0;
         status_mask_ff   <= htfd_pkg::STATUS_MASK_RESET;
         status_expect_ff <= htfd_pkg::STATUS_EXPECT_RESET;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         status_ff    <= status_in;
         hum_raw_ff   <= hum_raw_in;
         tmp_raw_ff   <= tmp_raw_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               htfd_pkg::CSR_STATUS_MASK:   status_mask_ff   <= csr_chan.wdata;
               htfd_pkg::CSR_STATUS_EXPECT: status_expect_ff <= csr_chan.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_hum_ff    <= out_hum_in;
      out_tmp_ff    <= out_tmp_in;
      out_code_ff   <= out_code_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.humidity_centi    = out_hum_ff;
   assign rsp_chan.temperature_centi = $signed(out_tmp_ff);
   assign rsp_chan.result_code       = out_code_ff;
   assign rsp_chan.status_copy       = out_status_ff;

endmodule
`default_nettype wire

FILE: design/htfd_checker.sv
`default_nettype none
module htfd_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire [htfd_pkg::HUM_W-1:0]           rsp_humidity_centi,
   input wire signed [htfd_pkg::TEMP_W-1:0]   rsp_temperature_centi,
   input wire [1:0]                           rsp_result_code,
   input wire [htfd_pkg::BYTE_W-1:0]          rsp_status_copy
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_humidity_centi)
         && $stable(rsp_temperature_centi) && $stable(rsp_result_code)
         && $stable(rsp_status_copy))
      else $error("stalled result changed");

   a_busy_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_copy[htfd_pkg::BUSY_BIT]
         |-> rsp_result_code == htfd_pkg::RC_BUSY)
      else $error("busy status not reported as busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code != htfd_pkg::RC_OK
         |-> rsp_humidity_centi == '0 && rsp_temperature_centi == '0)
      else $error("error result carries readings");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code == htfd_pkg::RC_OK
         |-> rsp_humidity_centi <= 14'd9999 && rsp_temperature_centi >= -15'sd5000
             && rsp_temperature_centi <= 15'sd14999)
      else $error("reading out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_humidity_centi    (rsp_chan.humidity_centi),
   .rsp_temperature_centi (rsp_chan.temperature_centi),
   .rsp_result_code       (rsp_chan.result_code),
   .rsp_status_copy       (rsp_chan.status_copy)
);
`default_nettype wire
